[hw/rtl/uvs_pkg.sv]
// Shared types and constants for the unique value stack.
`timescale 1ns / 1ps

package uvs_pkg;

    // Default number of stack entries
    localparam int DEPTH_DEF = 64;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_MIDDLE = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FOUND     = 3'd5,
        ST_NOT_FOUND = 3'd6,
        ST_MIDDLE    = 3'd7
    } status_t;

endpackage

[hw/rtl/uvs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module uvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/unique_value_stack.sv]
// Top level of the unique value stack: control, scan sequencer and result register.
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit values that never holds a value twice. Entries
// live in one RAM with a registered read; the stack pointer is a register.
// One item is worked at a time. Push and search scan the stored entries
// through the single RAM read port, one entry per cycle. A match ends the
// scan early. Pop and middle read one entry, issued on acceptance; the
// result is registered when the item leaves S_FIN. A finished result sits
// in an output register, and the next item is accepted while it waits to
// be taken. That next item then holds in its final cycle until the waiting
// result is taken. Reset clears the entry count; RAM contents need no
// clearing since only slots below the count are ever read.
module unique_value_stack
    import uvs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  data,
    output logic [SLOT_W-1:0]          slot_index,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [VALUE_W-1:0]  key_reg, key_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic [CW-1:0]       count_reg, count_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  data_reg, data_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [COUNT_W-1:0]  ecount_reg, ecount_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [VALUE_W-1:0]  ram_q;

    logic [CW-1:0]       top_pos;
    logic [CW-1:0]       mid_pos;
    logic                is_empty;
    logic                is_full;
    logic                accept;
    logic                retire;

    // Entry store
    uvs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Stack position helpers
    assign top_pos  = count_reg - CW'(1);
    assign mid_pos  = top_pos - (count_reg >> 1);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign retire   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign ram_we    = retire && (op_reg == OP_PUSH) && !found_reg && !is_full;
    assign ram_waddr = count_reg[AW-1:0];

    // Sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        slot_next      = slot_reg;
        ecount_next    = ecount_reg;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(operation);
                    key_next   = value;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    unique case (op_t'(operation))
                        OP_PUSH, OP_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_POP:
                        begin
                            ram_re     = !is_empty;
                            ram_raddr  = top_pos[AW-1:0];
                            state_next = S_FIN;
                        end
                        OP_MIDDLE:
                        begin
                            ram_re     = !is_empty;
                            ram_raddr  = mid_pos[AW-1:0];
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle, then issue the next read
                if (pend_reg && (ram_q == key_reg))
                begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            S_FIN:
            begin
                if (retire)
                begin
                    data_next = '0;
                    slot_next = '0;
                    unique case (op_reg)
                        OP_PUSH:
                        begin
                            if (found_reg)
                            begin
                                status_next = ST_DUPLICATE;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_PUSHED;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ST_POPPED;
                                data_next   = ram_q;
                                count_next  = top_pos;
                            end
                        end
                        OP_SEARCH:
                        begin
                            status_next = found_reg ? ST_FOUND : ST_NOT_FOUND;
                        end
                        OP_MIDDLE:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ST_MIDDLE;
                                data_next   = ram_q;
                                slot_next   = SLOT_W'(mid_pos);
                            end
                        end
                        default:
                        begin
                            status_next = ST_EMPTY;
                        end
                    endcase
                    ecount_next    = COUNT_W'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        slot_reg   <= slot_next;
        ecount_reg <= ecount_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data        = data_reg;
    assign slot_index  = slot_reg;
    assign entry_count = ecount_reg;

endmodule
